FILE: hdl/deadlock_detecting_resource_ledger_core_assert.svh
// Assertion macros for the deadlock ledger.
`ifndef DEADLOCK_DETECTING_RESOURCE_LEDGER_CORE_ASSERT_SVH
`define DEADLOCK_DETECTING_RESOURCE_LEDGER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DDRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DDRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/ddrl_pkg.sv
// ----------------------------------------------------------------------------
// ddrl_pkg
// Shared types and codes of the deadlock-detecting resource ledger.
// ----------------------------------------------------------------------------
package ddrl_pkg;
    localparam int CNT_W  = 8;
    localparam int WORK_W = 9;
    localparam logic [CNT_W-1:0]  CNT_MAX  = 8'd255;
    localparam logic [WORK_W-1:0] WORK_MAX = 9'd511;

    typedef enum logic [1:0] {
        ACT_SET     = 2'd0,
        ACT_REQUEST = 2'd1,
        ACT_ACQUIRE = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_DEADLOCK = 2'd2
    } t_status;

    localparam logic CFG_DETECT_ENABLE = 1'b0;
    localparam logic CFG_RES_IN_USE    = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_MARK_RD,
        S_MARK,
        S_PASS_RD,
        S_PASS,
        S_DECIDE,
        S_ROLLBACK,
        S_OUT
    } t_state;
endpackage

FILE: hdl/deadlock_detecting_resource_ledger_core.sv
// ----------------------------------------------------------------------------
// deadlock_detecting_resource_ledger_core
// Semaphore ledger with banker-style deadlock detection on each request while detection is enabled.
// ----------------------------------------------------------------------------
// Held and wanted counts live in memories with one row per thread (all
// resources side by side, registered read). After reset a clearing pass
// over every thread row zeroes both memories; no item is taken meanwhile.
// Set, acquire, release and undetected requests pass through READ, UPDATE
// and OUT before the core returns to IDLE. A detected request runs a
// marking pass (read and mark per thread row) and then up to THREADS+1
// passes over the thread rows, each row read and compared against the
// work vector, then DECIDE and, on deadlock, ROLLBACK of the wanted count.
// The result beat sits in an output register, and a result beat that is not
// yet taken holds off the next input beat.
module deadlock_detecting_resource_ledger_core #(
    parameter int THREADS   = 16,
    parameter int RESOURCES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] action, [5:2] thread, [8:6] resource, [16:9] count, rest zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, rest zero
    output logic [7:0]  m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int TW  = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int RW  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int ROW = RESOURCES * ddrl_pkg::CNT_W;

    ddrl_pkg::t_state r_state, n_state;

    logic r_detect, r_cfg_ready;
    logic [3:0] r_in_use;
    logic [1:0] r_act;
    logic [2:0] r_res_raw;
    logic [7:0] r_cnt;
    logic [TW-1:0] r_thr, r_t;
    logic [RW-1:0] r_res;
    logic [ddrl_pkg::CNT_W-1:0] r_avail [RESOURCES];
    logic [ddrl_pkg::WORK_W-1:0] r_work [RESOURCES];
    logic [THREADS-1:0] r_fin;
    logic r_prog;
    logic [ddrl_pkg::CNT_W-1:0] r_before;
    logic [1:0] r_status;
    logic r_oval;

    logic [ROW-1:0] mem_held [THREADS];
    logic [ROW-1:0] mem_want [THREADS];
    logic [ROW-1:0] r_hrd, r_wrd;
    logic           mem_we;
    logic [TW-1:0]  mem_wa, mem_ra;
    logic [ROW-1:0] mem_hwd, mem_wwd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_held[mem_wa] <= mem_hwd;
            mem_want[mem_wa] <= mem_wwd;
        end
        r_hrd <= mem_held[mem_ra];
        r_wrd <= mem_want[mem_ra];
    end

    // Thread modulo THREADS, via a compare-and-subtract loop on 4 bits.
    logic [4:0] thr_mod;
    always_comb begin
        thr_mod = {1'b0, s_axis_tdata[5:2]};
        for (int k = 0; k < 8; k++) begin
            if (thr_mod >= 5'(THREADS)) thr_mod = thr_mod - 5'(THREADS);
        end
    end

    logic bad_id;
    assign bad_id = ({1'b0, r_res_raw} >= r_in_use) || (32'(r_res_raw) >= RESOURCES);

    logic in_take;
    assign in_take = s_axis_tvalid && s_axis_tready;

    // Current-cell fields of the read row.
    logic [7:0] h_cur, w_cur;
    assign h_cur = r_hrd[r_res*8 +: 8];
    assign w_cur = r_wrd[r_res*8 +: 8];

    logic busy, fits;
    always_comb begin
        busy = 1'b0;
        fits = 1'b1;
        for (int r = 0; r < RESOURCES; r++) begin
            if (r_hrd[r*8 +: 8] != 8'd0 || r_wrd[r*8 +: 8] != 8'd0) busy = 1'b1;
            if ({1'b0, r_wrd[r*8 +: 8]} > r_work[r]) fits = 1'b0;
        end
    end

    logic last_t;
    assign last_t = (32'(r_t) == THREADS - 1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ddrl_pkg::S_CLEAR:  if (last_t) n_state = ddrl_pkg::S_IDLE;
            ddrl_pkg::S_IDLE:   if (in_take) n_state = ddrl_pkg::S_READ;
            ddrl_pkg::S_READ:   n_state = ddrl_pkg::S_UPDATE;
            ddrl_pkg::S_UPDATE: begin
                if (bad_id) n_state = ddrl_pkg::S_OUT;
                else if (r_act == ddrl_pkg::ACT_REQUEST && r_detect)
                    n_state = ddrl_pkg::S_MARK_RD;
                else n_state = ddrl_pkg::S_OUT;
            end
            ddrl_pkg::S_MARK_RD: n_state = ddrl_pkg::S_MARK;
            ddrl_pkg::S_MARK: n_state = last_t ? ddrl_pkg::S_PASS_RD : ddrl_pkg::S_MARK_RD;
            ddrl_pkg::S_PASS_RD: n_state = ddrl_pkg::S_PASS;
            ddrl_pkg::S_PASS: begin
                if (!last_t) n_state = ddrl_pkg::S_PASS_RD;
                else if (r_prog || (!r_fin[r_t] && fits)) n_state = ddrl_pkg::S_PASS_RD;
                else n_state = ddrl_pkg::S_DECIDE;
            end
            ddrl_pkg::S_DECIDE:
                n_state = (&r_fin) ? ddrl_pkg::S_OUT : ddrl_pkg::S_ROLLBACK;
            ddrl_pkg::S_ROLLBACK: n_state = ddrl_pkg::S_OUT;
            ddrl_pkg::S_OUT: if (!r_oval || m_axis_tready) n_state = ddrl_pkg::S_IDLE;
            default: n_state = ddrl_pkg::S_IDLE;
        endcase
    end

    // Memory port control.
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_thr;
        mem_ra  = r_thr;
        mem_hwd = r_hrd;
        mem_wwd = r_wrd;
        unique case (r_state)
            ddrl_pkg::S_CLEAR: begin
                mem_we  = 1'b1;
                mem_wa  = r_t;
                mem_hwd = '0;
                mem_wwd = '0;
            end
            ddrl_pkg::S_IDLE: mem_ra = TW'(thr_mod);
            ddrl_pkg::S_UPDATE: begin
                if (!bad_id && r_act != ddrl_pkg::ACT_SET) begin
                    mem_we = 1'b1;
                    case (r_act)
                        ddrl_pkg::ACT_REQUEST:
                            mem_wwd[r_res*8 +: 8] = (w_cur == 8'd255) ? w_cur : w_cur + 8'd1;
                        ddrl_pkg::ACT_ACQUIRE: begin
                            mem_wwd[r_res*8 +: 8] = (w_cur == 8'd0) ? w_cur : w_cur - 8'd1;
                            mem_hwd[r_res*8 +: 8] = (h_cur == 8'd255) ? h_cur : h_cur + 8'd1;
                        end
                        default:
                            mem_hwd[r_res*8 +: 8] = (h_cur == 8'd0) ? h_cur : h_cur - 8'd1;
                    endcase
                end
            end
            ddrl_pkg::S_MARK_RD, ddrl_pkg::S_PASS_RD: mem_ra = r_t;
            ddrl_pkg::S_DECIDE: mem_ra = r_thr;
            ddrl_pkg::S_ROLLBACK: begin
                mem_we = 1'b1;
                mem_wwd[r_res*8 +: 8] = r_before;
            end
            default: ;
        endcase
    end

    // Hold off input while a result beat waits.
    assign s_axis_tready = (r_state == ddrl_pkg::S_IDLE) && (!r_oval || m_axis_tready);
    assign o_cfg_ready   = r_cfg_ready;
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = {6'd0, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ddrl_pkg::S_CLEAR;
            r_t         <= '0;
            r_detect    <= 1'b0;
            r_in_use    <= '0;
            r_oval      <= 1'b0;
            r_cfg_ready <= 1'b0;
            for (int r = 0; r < RESOURCES; r++) r_avail[r] <= '0;
        end else begin
            r_state     <= n_state;
            r_cfg_ready <= 1'b1;
            if (i_cfg_valid && r_cfg_ready) begin
                if (i_cfg_index == ddrl_pkg::CFG_DETECT_ENABLE) r_detect <= i_cfg_data[0];
                else r_in_use <= i_cfg_data;
            end
            if (r_state == ddrl_pkg::S_OUT && (!r_oval || m_axis_tready)) r_oval <= 1'b1;
            else if (r_oval && m_axis_tready) r_oval <= 1'b0;
            unique case (r_state)
                ddrl_pkg::S_CLEAR: r_t <= r_t + TW'(1);
                ddrl_pkg::S_IDLE: if (in_take) begin
                    r_act     <= s_axis_tdata[1:0];
                    r_thr     <= TW'(thr_mod);
                    r_res_raw <= s_axis_tdata[8:6];
                    r_res     <= RW'(s_axis_tdata[8:6]);
                    r_cnt     <= s_axis_tdata[16:9];
                end
                ddrl_pkg::S_UPDATE: begin
                    r_status <= bad_id ? ddrl_pkg::ST_BAD_ID : ddrl_pkg::ST_OK;
                    r_before <= w_cur;
                    r_t      <= '0;
                    if (!bad_id) begin
                        case (r_act)
                            ddrl_pkg::ACT_SET: r_avail[r_res] <= r_cnt;
                            ddrl_pkg::ACT_ACQUIRE: if (r_avail[r_res] != 8'd0)
                                r_avail[r_res] <= r_avail[r_res] - 8'd1;
                            ddrl_pkg::ACT_RELEASE: if (r_avail[r_res] != 8'd255)
                                r_avail[r_res] <= r_avail[r_res] + 8'd1;
                            default: ;
                        endcase
                    end
                    for (int r = 0; r < RESOURCES; r++) r_work[r] <= {1'b0, r_avail[r]};
                end
                ddrl_pkg::S_MARK: begin
                    r_fin[r_t] <= !busy;
                    r_t        <= last_t ? '0 : r_t + TW'(1);
                    r_prog     <= 1'b0;
                end
                ddrl_pkg::S_PASS: begin
                    if (!r_fin[r_t] && fits) begin
                        r_fin[r_t] <= 1'b1;
                        for (int r = 0; r < RESOURCES; r++) begin
                            if ({1'b0, r_work[r]} + 10'(r_hrd[r*8 +: 8]) > 10'd511)
                                r_work[r] <= ddrl_pkg::WORK_MAX;
                            else r_work[r] <= r_work[r] + 9'(r_hrd[r*8 +: 8]);
                        end
                    end
                    if (last_t) begin
                        r_t    <= '0;
                        r_prog <= 1'b0;
                    end else begin
                        r_t    <= r_t + TW'(1);
                        if (!r_fin[r_t] && fits) r_prog <= 1'b1;
                    end
                end
                ddrl_pkg::S_DECIDE:
                    if (!(&r_fin)) r_status <= ddrl_pkg::ST_DEADLOCK;
                default: ;
            endcase
        end
    end
endmodule

FILE: hdl/ddrl_checker.sv
// ----------------------------------------------------------------------------
// ddrl_checker
// Port-level checks of the ledger core.
// ----------------------------------------------------------------------------
`include "deadlock_detecting_resource_ledger_core_assert.svh"
module ddrl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);
    `DDRL_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `DDRL_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[7:2] == 6'd0)
    `DDRL_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `DDRL_ASSERT_IMP(a_no_take_pending, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
endmodule

bind deadlock_detecting_resource_ledger_core ddrl_checker u_ddrl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
